[rtl/sensor_packet_deframer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the sensor packet deframer
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SENSOR_PACKET_DEFRAMER_MACROS_SVH
`define SENSOR_PACKET_DEFRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/spd_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer package
// Shared types and constants for the header hunt and packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    // Header bytes 's', 'n', 'p'
    localparam logic [7:0] HDR_S = 8'h73;
    localparam logic [7:0] HDR_N = 8'h6E;
    localparam logic [7:0] HDR_P = 8'h70;

    // Sum of the three header bytes, the starting value of the checksum
    localparam logic [15:0] HEADER_SUM = 16'(HDR_S) + 16'(HDR_N) + 16'(HDR_P);

    // Packed output beat width: 8+8+8+6+6 bits, padded to whole bytes
    localparam int OUT_FIELDS_W = 36;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Parser phases
    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_TYPE = 3'd1,
        PH_ADDR = 3'd2,
        PH_DATA = 3'd3,
        PH_CKHI = 3'd4,
        PH_CKLO = 3'd5
    } spd_phase_t;

    // One result item
    typedef struct packed {
        logic [7:0] packet_address;
        logic [7:0] packet_type;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic [5:0] payload_length;
        logic       is_last;
        logic       checksum_ok;
    } spd_result_t;

    // Payload length from the type byte: none without the has-data bit,
    // four for a single sample, otherwise four times the batch count.
    function automatic logic [5:0] decode_length(input logic [7:0] t);
        logic [5:0] len;
        begin
            if (!t[7])
            begin
                len = 6'd0;
            end
            else if (!t[6])
            begin
                len = 6'd4;
            end
            else
            begin
                len = {t[5:2], 2'b00};
            end
            return len;
        end
    endfunction

endpackage

`default_nettype wire

[rtl/spd_parser.sv]
// ----------------------------------------------------------------------------
// Sensor packet parser
// Header hunt, type/address capture, payload indexing and checksum check,
// advancing by one byte on each step strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_parser
    import spd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [7:0]  rx_byte,
    output logic             res_valid,
    output spd_result_t      res
);

    spd_phase_t  phase_reg, phase_next;
    logic [1:0]  matched_reg, matched_next;
    logic [7:0]  type_reg, type_next;
    logic [7:0]  address_reg, address_next;
    logic [5:0]  length_reg, length_next;
    logic [5:0]  seen_reg, seen_next;
    logic [15:0] sum_reg, sum_next;
    logic [7:0]  ckhi_reg, ckhi_next;
    logic [15:0] sum_plus;
    logic [5:0]  seen_inc;

    assign sum_plus = sum_reg + 16'(rx_byte);
    assign seen_inc = seen_reg + 6'd1;

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT:
            begin
                if (matched_reg == 2'd2 && rx_byte == HDR_P)
                begin
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE: phase_next = PH_ADDR;
            PH_ADDR: phase_next = (length_reg == 6'd0) ? PH_CKHI : PH_DATA;
            PH_DATA:
            begin
                if (seen_inc >= length_reg)
                begin
                    phase_next = PH_CKHI;
                end
            end
            PH_CKHI: phase_next = PH_CKLO;
            PH_CKLO: phase_next = PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    // Datapath updates and result item
    always_comb
    begin
        matched_next = matched_reg;
        type_next    = type_reg;
        address_next = address_reg;
        length_next  = length_reg;
        seen_next    = seen_reg;
        sum_next     = sum_reg;
        ckhi_next    = ckhi_reg;
        res_valid    = 1'b0;
        res.packet_address = address_reg;
        res.packet_type    = type_reg;
        res.payload_byte   = 8'd0;
        res.byte_index     = 6'd0;
        res.payload_length = length_reg;
        res.is_last        = 1'b0;
        res.checksum_ok    = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (matched_reg == 2'd2 && rx_byte == HDR_P)
                begin
                    matched_next = 2'd0;
                    sum_next     = HEADER_SUM;
                end
                else if (matched_reg == 2'd1 && rx_byte == HDR_N)
                begin
                    matched_next = 2'd2;
                end
                else if (rx_byte == HDR_S)
                begin
                    // An 's' that breaks a partial match starts a new header.
                    matched_next = 2'd1;
                end
                else
                begin
                    matched_next = 2'd0;
                end
            end
            PH_TYPE:
            begin
                type_next   = rx_byte;
                length_next = decode_length(rx_byte);
                sum_next    = sum_plus;
            end
            PH_ADDR:
            begin
                address_next = rx_byte;
                sum_next     = sum_plus;
                seen_next    = 6'd0;
            end
            PH_DATA:
            begin
                sum_next         = sum_plus;
                seen_next        = seen_inc;
                res_valid        = 1'b1;
                res.payload_byte = rx_byte;
                res.byte_index   = seen_reg;
            end
            PH_CKHI:
            begin
                ckhi_next = rx_byte;
            end
            PH_CKLO:
            begin
                matched_next    = 2'd0;
                res_valid       = 1'b1;
                res.is_last     = 1'b1;
                res.checksum_ok = ({ckhi_reg, rx_byte} == sum_reg);
            end
            default:
            begin
                matched_next = 2'd0;
            end
        endcase
    end

    // State registers, advanced once per consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HUNT;
            matched_reg <= 2'd0;
            type_reg    <= 8'd0;
            address_reg <= 8'd0;
            length_reg  <= 6'd0;
            seen_reg    <= 6'd0;
            sum_reg     <= 16'd0;
            ckhi_reg    <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            matched_reg <= matched_next;
            type_reg    <= type_next;
            address_reg <= address_next;
            length_reg  <= length_next;
            seen_reg    <= seen_next;
            sum_reg     <= sum_next;
            ckhi_reg    <= ckhi_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sensor_packet_deframer.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer
// Byte stream in, one beat per payload byte and one end-of-packet beat out.
// ----------------------------------------------------------------------------
// Usage:
// Received bytes enter on the s_axis channel, one byte per beat. The block
// hunts for the 's','n','p' header, takes the type and address bytes, then
// emits one m_axis beat per payload byte and, after the two big-endian
// checksum bytes, one beat with tlast high whose tuser bit says whether the
// 16-bit wrapping sum of header, type, address and payload matched.
// Header, type, address and high checksum bytes produce no output beat.
// An accepted byte is held in the input register and parsed there by the
// single-pass parser; its result beat is registered in the output register,
// which presents it to the receiver.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single-pass parser between the input and output registers.
// When the receiver stalls, the output register holds its beat; one further
// byte is still taken into the input register, after which s_axis_tready
// drops until the output beat is taken.
// Reset clears the parser to the header hunt and empties both registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sensor_packet_deframer_macros.svh"

module sensor_packet_deframer
    import spd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [7:0]             s_axis_tdata,   // [7:0] rx_byte
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // [7:0] packet_address, [15:8] packet_type, [23:16] payload_byte,
    // [29:24] byte_index, [35:30] payload_length, [39:36] zero
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic [0:0]                  m_axis_tuser,   // [0] checksum_ok
    output logic                        m_axis_tlast    // is_last
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        out_valid_reg;
    spd_result_t out_reg;
    logic        out_free;
    logic        step;
    logic        res_valid;
    spd_result_t res;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
        end
    end

    // Parser
    spd_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= step && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res_valid)
        begin
            out_reg <= res;
        end
    end

    // Beat packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            out_reg.payload_length, out_reg.byte_index,
                            out_reg.payload_byte, out_reg.packet_type,
                            out_reg.packet_address};
    assign m_axis_tuser  = out_reg.checksum_ok;
    assign m_axis_tlast  = out_reg.is_last;

    // Checks
    `SPD_ASSERT_NOW(a_end_beat_no_payload, out_valid_reg && out_reg.is_last, out_reg.payload_byte == 8'd0 && out_reg.byte_index == 6'd0, "end beat carries payload")
    `SPD_ASSERT_NOW(a_payload_no_verdict, out_valid_reg && !out_reg.is_last, !out_reg.checksum_ok, "payload beat carries a checksum verdict")
    `SPD_ASSERT_NOW(a_index_in_range, out_valid_reg && !out_reg.is_last, out_reg.byte_index < out_reg.payload_length, "payload index beyond decoded length")
    `SPD_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, in_valid_reg && out_valid_reg, "input stalled with room to spare")
    `SPD_ASSERT_NEXT(a_stall_holds_beat, out_valid_reg && !m_axis_tready, out_valid_reg && $stable(out_reg), "stalled output beat changed")

endmodule

`default_nettype wire

[tb/sensor_packet_deframer_tb.sv]
// ----------------------------------------------------------------------------
// Sensor packet deframer testbench
// Feeds the deframer a byte stream of 'snp' packets mixed with line noise,
// partial headers and bad checksums. Each accepted byte is parsed by a local
// model that builds the payload and end-of-packet beats the block should
// produce. Every output beat is then checked field by field against them.
// Both sides of the stream idle at random, except in the closing stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_packet_deframer_tb;
    import spd_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int ITEM_COUNT     = 1250;
    localparam int QUIET_TAIL     = 150;
    localparam int DRAIN_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 400000;

    typedef logic [7:0] byte_list_t[$];

    // Byte-level parser model and the queue of beats it still expects to see.
    class deframer_checker;
        spd_phase_t  phase;
        logic [1:0]  hdr_hits;
        logic [7:0]  pkt_type;
        logic [7:0]  pkt_addr;
        logic [7:0]  ck_high;
        logic [5:0]  pkt_len;
        logic [5:0]  pay_idx;
        logic [15:0] sum;
        spd_result_t pending_beats[$];
        int          fails;

        function new();
            phase    = PH_HUNT;
            hdr_hits = 2'd0;
            pkt_type = 8'd0;
            pkt_addr = 8'd0;
            ck_high  = 8'd0;
            pkt_len  = 6'd0;
            pay_idx  = 6'd0;
            sum      = 16'd0;
            fails    = 0;
        endfunction

        // Advance the model by one received byte and queue any beat it causes.
        function void parse_byte(logic [7:0] b);
            spd_result_t beat;
            beat = '0;
            case (phase)
                PH_HUNT:
                begin
                    // A stray 's' always restarts the header match.
                    if (hdr_hits == 2'd2 && b == HDR_P)
                    begin
                        hdr_hits = 2'd0;
                        sum      = HEADER_SUM;
                        phase    = PH_TYPE;
                    end
                    else if (hdr_hits == 2'd1 && b == HDR_N)
                    begin
                        hdr_hits = 2'd2;
                    end
                    else if (b == HDR_S)
                    begin
                        hdr_hits = 2'd1;
                    end
                    else
                    begin
                        hdr_hits = 2'd0;
                    end
                end
                PH_TYPE:
                begin
                    pkt_type = b;
                    if (!b[7])
                    begin
                        pkt_len = 6'd0;
                    end
                    else if (!b[6])
                    begin
                        pkt_len = 6'd4;
                    end
                    else
                    begin
                        pkt_len = 6'(b[5:2]) * 6'd4;
                    end
                    sum   = sum + 16'(b);
                    phase = PH_ADDR;
                end
                PH_ADDR:
                begin
                    pkt_addr = b;
                    sum      = sum + 16'(b);
                    pay_idx  = 6'd0;
                    phase    = (pkt_len == 6'd0) ? PH_CKHI : PH_DATA;
                end
                PH_DATA:
                begin
                    sum                 = sum + 16'(b);
                    beat.packet_address = pkt_addr;
                    beat.packet_type    = pkt_type;
                    beat.payload_byte   = b;
                    beat.byte_index     = pay_idx;
                    beat.payload_length = pkt_len;
                    pending_beats.push_back(beat);
                    pay_idx = pay_idx + 6'd1;
                    if (pay_idx >= pkt_len)
                    begin
                        phase = PH_CKHI;
                    end
                end
                PH_CKHI:
                begin
                    ck_high = b;
                    phase   = PH_CKLO;
                end
                PH_CKLO:
                begin
                    beat.packet_address = pkt_addr;
                    beat.packet_type    = pkt_type;
                    beat.payload_length = pkt_len;
                    beat.is_last        = 1'b1;
                    beat.checksum_ok    = ({ck_high, b} == sum);
                    pending_beats.push_back(beat);
                    phase    = PH_HUNT;
                    hdr_hits = 2'd0;
                end
                default:
                begin
                    phase    = PH_HUNT;
                    hdr_hits = 2'd0;
                end
            endcase
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", field, want, got);
                fails++;
            end
        endfunction

        // Check one output beat against the oldest outstanding expectation.
        function void check_beat(logic [OUT_TDATA_W-1:0] data, logic ok, logic last);
            spd_result_t want;
            if (pending_beats.size() == 0)
            begin
                $error("output beat with nothing expected: tdata %0h", data);
                fails++;
                return;
            end
            want = pending_beats.pop_front();
            compare_field("packet_address", want.packet_address, data[7:0]);
            compare_field("packet_type", want.packet_type, data[15:8]);
            compare_field("payload_byte", want.payload_byte, data[23:16]);
            compare_field("byte_index", 8'(want.byte_index), 8'(data[29:24]));
            compare_field("payload_length", 8'(want.payload_length), 8'(data[35:30]));
            compare_field("is_last", 8'(want.is_last), 8'(last));
            compare_field("checksum_ok", 8'(want.checksum_ok), 8'(ok));
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;

    deframer_checker chk = new();
    int              bytes_sent = 0;
    int              gap_odds   = 0;
    bit              quiet      = 1'b0;

    sensor_packet_deframer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Free-running clock.
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Offer one byte, with an occasional gap first, and wait until it is accepted.
    task automatic send_byte(input logic [7:0] b);
        logic took;
        if (!quiet && gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do
        begin
            @(negedge clk);
            took = s_axis_tready;
            @(posedge clk);
        end
        while (!took);
        chk.parse_byte(b);
        bytes_sent++;
    endtask

    // Send a whole packet; the checksum is spoilt on request.
    task automatic send_packet(input logic [7:0] ptype, input logic [7:0] addr,
                               input byte_list_t payload, input bit corrupt);
        logic [15:0] total;
        total = HEADER_SUM + 16'(ptype) + 16'(addr);
        send_byte(HDR_S);
        send_byte(HDR_N);
        send_byte(HDR_P);
        send_byte(ptype);
        send_byte(addr);
        foreach (payload[i])
        begin
            send_byte(payload[i]);
            total = total + 16'(payload[i]);
        end
        if (corrupt)
        begin
            total = total ^ 16'($urandom_range(1, 65535));
        end
        send_byte(total[15:8]);
        send_byte(total[7:0]);
    endtask

    // A byte that is often one of the header characters.
    function automatic logic [7:0] tricky_byte();
        case ($urandom_range(0, 3))
            0: return HDR_S;
            1: return HDR_N;
            2: return HDR_P;
            default: return 8'($urandom);
        endcase
    endfunction

    // Stimulus: reset, a short directed set of packets, then random traffic.
    initial
    begin
        byte_list_t payload;
        logic [7:0] ptype;
        logic [3:0] count;
        int         len;
        int         kind;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header restart on a stray 's', then a packet with no data bit.
        gap_odds = 4;
        send_byte(HDR_S);
        send_byte(HDR_S);
        send_byte(HDR_N);
        payload = {};
        send_packet(8'h7F, 8'hFF, payload, 1'b0);
        // Batch packet with a count of zero and a bad checksum.
        send_packet(8'hC0, 8'h00, payload, 1'b1);
        // Single sample whose payload holds extreme values and header bytes.
        payload = {8'h00, 8'hFF, HDR_S, HDR_N};
        send_packet(8'h80, 8'h5A, payload, 1'b0);

        // Random traffic: mostly well-formed packets, some noise and breaks.
        while (bytes_sent < ITEM_COUNT)
        begin
            quiet = (bytes_sent >= ITEM_COUNT - QUIET_TAIL);
            case ($urandom_range(0, 3))
                0: gap_odds = 0;
                1: gap_odds = 3;
                2: gap_odds = 8;
                default: gap_odds = 20;
            endcase

            // Line noise between packets, often partial headers.
            if ($urandom_range(0, 3) == 0)
            begin
                repeat ($urandom_range(1, 4)) send_byte(tricky_byte());
            end

            // A header with a random third byte, so it usually breaks off before the 'p'.
            if ($urandom_range(0, 11) == 0)
            begin
                send_byte(HDR_S);
                send_byte(HDR_N);
                send_byte(8'($urandom));
            end
            else
            begin
                kind = $urandom_range(0, 9);
                if (kind < 2)
                begin
                    ptype = {1'b0, 7'($urandom)};
                    len   = 0;
                end
                else if (kind < 5)
                begin
                    ptype = {2'b10, 6'($urandom)};
                    len   = 4;
                end
                else
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        count = ($urandom_range(0, 1) == 0) ? 4'hF : 4'($urandom);
                    end
                    else
                    begin
                        count = 4'($urandom_range(0, 3));
                    end
                    ptype = {2'b11, count, 2'($urandom)};
                    len   = 4 * count;
                end
                payload = {};
                repeat (len)
                begin
                    payload.push_back(($urandom_range(0, 7) == 0) ? tricky_byte()
                                                                   : 8'($urandom));
                end
                send_packet(ptype, 8'($urandom), payload, $urandom_range(0, 5) == 0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain everything still expected, then watch for stray beats.
        while (chk.pending_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (chk.fails == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver back-pressure in random bursts, none in the closing stretch.
    initial
    begin
        int stall_left;
        int stall_odds;
        m_axis_tready = 1'b0;
        stall_left    = 0;
        stall_odds    = 6;
        forever
        begin
            @(posedge clk);
            if ($urandom_range(0, 63) == 0)
            begin
                stall_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 20);
            end
            if (quiet)
            begin
                stall_left = 0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!quiet && stall_odds != 0 && $urandom_range(0, stall_odds - 1) == 0)
            begin
                stall_left = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Output monitor: signals are settled mid-cycle, so a beat seen here is
    // taken at the next rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                chk.check_beat(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
            end
        end
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
